/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/fcrm_pkg.sv */
// Package for the cluster chain read mapper: widths, codes and helpers.
// No dependencies.
package fcrm_pkg;

  localparam int unsigned FCRM_FAT_ENTRIES  = 4096;
  localparam int unsigned FCRM_MAX_SEGMENTS = 64;

  localparam int unsigned CLUSTER_W = 28;
  localparam int unsigned FAT_IDX_W = 12;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned SEG_W     = 20;
  localparam int unsigned OFF_W     = 19;  // widest in-cluster offset (4 KiB x 128)
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CLUSTER_W-1:0] EOC_MASK = 28'hFFFFFF8;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_START = 2'd0,
    CFG_SPC_LOG2   = 2'd1,
    CFG_BPS_LOG2   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BEYOND  = 2'd1,
    ST_TRUNC   = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_e;

  function automatic logic is_eoc(input logic [CLUSTER_W-1:0] c);
    return (c & EOC_MASK) == EOC_MASK;
  endfunction

endpackage

/* rtl/fcrm_if.sv */
// Channel interfaces of the cluster chain read mapper: requests, results,
// configuration writes. Depends on fcrm_pkg.
interface fcrm_req_if import fcrm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [FAT_IDX_W-1:0] fat_index;
  logic [CLUSTER_W-1:0] fat_value;
  logic [CLUSTER_W-1:0] first_cluster;
  logic [WORD_W-1:0]    file_size;
  logic [WORD_W-1:0]    position;
  logic [WORD_W-1:0]    length;

  modport source (output valid, action, fat_index, fat_value, first_cluster,
                  file_size, position, length, input ready);
  modport sink   (input valid, action, fat_index, fat_value, first_cluster,
                  file_size, position, length, output ready);
endinterface

interface fcrm_res_if import fcrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] byte_address;
  logic [SEG_W-1:0]  segment_length;
  logic              last;
  logic [1:0]        status;
  logic [WORD_W-1:0] total_bytes;

  modport source (output valid, byte_address, segment_length, last, status,
                  total_bytes, input ready);
  modport sink   (input valid, byte_address, segment_length, last, status,
                  total_bytes, output ready);
endinterface

interface fcrm_cfg_if import fcrm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/fcrm_ram.sv */
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
module fcrm_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fat_cluster_chain_read_mapper.sv */
// FAT32 cluster chain read mapper. A request item either loads one
// allocation table entry (action 0) or asks for a read (action 1): the block
// clips the length to the file, walks the chain to the position and sends one
// result item per cluster touched, the final one marked last with the status.
// A config channel sets data start sector, sectors and bytes per cluster/sector.
// The pace is set by the single-port table memory with its registered read
// data: each cluster skipped is read in S_SEEK and taken in S_SEEK_RD; each
// segment passes S_MAP and S_ADDR, then S_NEXT while length is left. One
// request is in work at a time; the next is taken once the final result
// sits in the output register.
// Reset clears the config registers to 0, 0, 9 and empties the output; the
// table itself holds no reset value and must be written before it is read.
// A stalled result channel holds the output register and the walk waits for
// it, so no result is lost.
// Depends on fcrm_pkg, fcrm_if, fcrm_ram and assert_macros.svh.
`include "assert_macros.svh"

module fat_cluster_chain_read_mapper import fcrm_pkg::*; #(
  parameter int unsigned FAT_ENTRIES  = FCRM_FAT_ENTRIES,
  parameter int unsigned MAX_SEGMENTS = FCRM_MAX_SEGMENTS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcrm_req_if.sink   req_i,
  fcrm_cfg_if.sink   cfg_i,
  fcrm_res_if.source res_o
);

  localparam int unsigned FatAw = $clog2(FAT_ENTRIES);
  localparam int unsigned CntW  = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEEK, S_SEEK_RD, S_MAP, S_ADDR, S_NEXT, S_DONE
  } state_e;

  state_e               state_q;
  logic [WORD_W-1:0]    dss_q;
  logic [2:0]           spc_q;
  logic [3:0]           bps_q;
  logic [CLUSTER_W-1:0] cluster_q;
  logic [WORD_W-1:0]    left_q;
  logic [WORD_W-1:0]    len_q;
  logic [OFF_W-1:0]     skip_q;
  logic [WORD_W-1:0]    total_q;
  logic [WORD_W:0]      sum_q;
  logic [SEG_W-1:0]     seg_q;
  logic [CntW-1:0]      cnt_q;
  status_e              status_q;
  logic                 pend_valid_q;
  logic [ADDR_W-1:0]    pend_addr_q;
  logic [SEG_W-1:0]     pend_seg_q;
  logic [WORD_W-1:0]    pend_total_q;
  logic                 out_valid_q;
  logic [ADDR_W-1:0]    out_addr_q;
  logic [SEG_W-1:0]     out_seg_q;
  logic                 out_last_q;
  status_e              out_status_q;
  logic [WORD_W-1:0]    out_total_q;

  logic [3:0]           bps_eff;
  logic [SHIFT_W-1:0]   sh;
  logic [SEG_W-1:0]     bpc;
  logic [SEG_W-1:0]     mask;
  logic [SEG_W-1:0]     room;
  logic [SEG_W-1:0]     seg_take;
  logic [ADDR_W+3:0]    addr_wide;
  logic [ADDR_W-1:0]    byte_addr;
  logic                 cl_eoc;
  logic                 cl_in_table;
  logic                 out_free;
  logic                 req_fire;
  logic                 pos_beyond;
  logic                 need_clip;
  logic                 ram_we;
  logic [FatAw-1:0]     ram_addr;
  logic [CLUSTER_W-1:0] ram_rdata;

  // sector size is clamped to 512..4096 bytes
  assign bps_eff = (bps_q < 4'd9) ? 4'd9 : ((bps_q > 4'd12) ? 4'd12 : bps_q);
  assign sh      = SHIFT_W'(bps_eff) + SHIFT_W'(spc_q);
  assign bpc     = SEG_W'(1) << sh;
  assign mask    = bpc - SEG_W'(1);
  assign room    = bpc - SEG_W'(skip_q);
  assign seg_take = (len_q < WORD_W'(room)) ? SEG_W'(len_q) : room;

  assign addr_wide = (ADDR_W+4)'(sum_q) << sh;
  assign byte_addr = addr_wide[ADDR_W-1:0] + ADDR_W'(skip_q);

  assign cl_eoc      = is_eoc(cluster_q);
  assign cl_in_table = (cluster_q >= CLUSTER_W'(2)) &&
                       (WORD_W'(cluster_q) < WORD_W'(FAT_ENTRIES));

  assign out_free   = !out_valid_q || res_o.ready;
  assign req_fire   = req_i.valid && req_i.ready;
  assign pos_beyond = req_i.position > req_i.file_size;
  assign need_clip  = (req_i.file_size != '0) &&
                      ((WORD_W+1)'(req_i.position) + (WORD_W+1)'(req_i.length) >
                       (WORD_W+1)'(req_i.file_size));

  assign ram_we   = req_fire && (req_i.action == ACT_WRITE) &&
                    (WORD_W'(req_i.fat_index) < WORD_W'(FAT_ENTRIES));
  assign ram_addr = (state_q == S_IDLE) ? FatAw'(req_i.fat_index)
                                        : cluster_q[FatAw-1:0];

  fcrm_ram #(
    .WIDTH (CLUSTER_W),
    .DEPTH (FAT_ENTRIES)
  ) u_fat (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (req_i.fat_value),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign res_o.valid          = out_valid_q;
  assign res_o.byte_address   = out_addr_q;
  assign res_o.segment_length = out_seg_q;
  assign res_o.last           = out_last_q;
  assign res_o.status         = out_status_q;
  assign res_o.total_bytes    = out_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dss_q        <= '0;
      spc_q        <= '0;
      bps_q        <= 4'd9;
      cluster_q    <= '0;
      left_q       <= '0;
      len_q        <= '0;
      skip_q       <= '0;
      total_q      <= '0;
      sum_q        <= '0;
      seg_q        <= '0;
      cnt_q        <= '0;
      status_q     <= ST_OK;
      pend_valid_q <= 1'b0;
      pend_addr_q  <= '0;
      pend_seg_q   <= '0;
      pend_total_q <= '0;
      out_valid_q  <= 1'b0;
      out_addr_q   <= '0;
      out_seg_q    <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= ST_OK;
      out_total_q  <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_DATA_START: dss_q <= cfg_i.data;
          CFG_SPC_LOG2:   spc_q <= cfg_i.data[2:0];
          CFG_BPS_LOG2:   bps_q <= cfg_i.data[3:0];
          default: ;
        endcase
      end

      if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (req_fire && (req_i.action == ACT_READ)) begin
            cluster_q <= req_i.first_cluster;
            left_q    <= req_i.position;
            skip_q    <= req_i.position[OFF_W-1:0] & mask[OFF_W-1:0];
            total_q   <= '0;
            cnt_q     <= '0;
            len_q     <= need_clip ? (req_i.file_size - req_i.position) : req_i.length;
            if (pos_beyond) begin
              status_q <= ST_BEYOND;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_SEEK;
            end
          end
        end
        S_SEEK: begin
          if ((left_q >= WORD_W'(bpc)) && (cluster_q != '0) && !cl_eoc) begin
            if (!cl_in_table) begin
              status_q <= ST_OUTSIDE;
              state_q  <= S_DONE;
            end else begin
              left_q  <= left_q - WORD_W'(bpc);
              state_q <= S_SEEK_RD;
            end
          end else if (cl_eoc) begin
            status_q <= ST_BEYOND;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_MAP;
          end
        end
        S_SEEK_RD: begin
          cluster_q <= ram_rdata;
          state_q   <= S_SEEK;
        end
        S_MAP: begin
          if ((len_q == '0) || (cluster_q == '0) || cl_eoc) begin
            status_q <= ST_OK;
            state_q  <= S_DONE;
          end else if (!cl_in_table) begin
            status_q <= ST_OUTSIDE;
            state_q  <= S_DONE;
          end else if (cnt_q >= CntW'(MAX_SEGMENTS)) begin
            status_q <= ST_TRUNC;
            state_q  <= S_DONE;
          end else if (!pend_valid_q || out_free) begin
            // the held segment is known not to be the final one now
            if (pend_valid_q) begin
              out_valid_q  <= 1'b1;
              out_addr_q   <= pend_addr_q;
              out_seg_q    <= pend_seg_q;
              out_last_q   <= 1'b0;
              out_status_q <= ST_OK;
              out_total_q  <= pend_total_q;
            end
            seg_q   <= seg_take;
            len_q   <= len_q - WORD_W'(seg_take);
            total_q <= total_q + WORD_W'(seg_take);
            sum_q   <= (WORD_W+1)'(dss_q) + (WORD_W+1)'(cluster_q - CLUSTER_W'(2));
            cnt_q   <= cnt_q + CntW'(1);
            state_q <= S_ADDR;
          end
        end
        S_ADDR: begin
          pend_valid_q <= 1'b1;
          pend_addr_q  <= byte_addr;
          pend_seg_q   <= seg_q;
          pend_total_q <= total_q;
          skip_q       <= '0;
          state_q      <= (len_q != '0) ? S_NEXT : S_MAP;
        end
        S_NEXT: begin
          cluster_q <= ram_rdata;
          state_q   <= S_MAP;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_addr_q   <= pend_valid_q ? pend_addr_q : '0;
            out_seg_q    <= pend_valid_q ? pend_seg_q : '0;
            out_total_q  <= pend_valid_q ? pend_total_q : '0;
            out_last_q   <= 1'b1;
            out_status_q <= status_q;
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_idle_no_pend, clk_i, rst_ni, state_q == S_IDLE, !pend_valid_q)
  `ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MAX_SEGMENTS))
  `ASSERT_IMPL(a_mid_has_pend, clk_i, rst_ni, out_valid_q && !out_last_q, pend_valid_q)
  `ASSERT_NEXT(a_done_emits, clk_i, rst_ni, (state_q == S_DONE) && out_free, out_valid_q && out_last_q)

endmodule
